// ----- design/cfr_pkg.sv -----
// Shared types, constants and small lookup functions for the command frame receiver.
// Used by the controller, the datapath and the top level. Depends on nothing.
`timescale 1ns / 1ps

package cfr_pkg;

  // Default values of the top-level parameters.
  localparam int LENGTH_LIMIT_DEF   = 50;
  localparam int STORED_PAYLOAD_DEF = 18;

  // Frame byte values.
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT = 8'hF1;

  // Function codes.
  localparam logic [7:0] FN_GAIN_LOW  = 8'h10;
  localparam logic [7:0] FN_GAIN_HIGH = 8'h11;
  localparam logic [7:0] FN_DRIVE     = 8'h22;
  localparam logic [7:0] FN_CONTROL   = 8'h02;

  // Subcommand codes of the control function.
  localparam logic [7:0] SUB_READBACK   = 8'h01;
  localparam logic [7:0] SUB_ZERO_GAINS = 8'hA1;
  localparam logic [7:0] SUB_ANGLE_RST  = 8'hA2;
  localparam logic [7:0] SUB_MANUAL     = 8'hA4;
  localparam logic [7:0] SUB_POS_ZEROED = 8'hA5;
  localparam logic [7:0] SUB_AUTO       = 8'hA6;

  // Acknowledge frame bytes.
  localparam logic [7:0] ACK_TAG = 8'hEF;
  localparam logic [7:0] ACK_FN  = 8'h02;
  // Sum of the four fixed acknowledge bytes, the seed of the acknowledge checksum.
  localparam logic [7:0] ACK_CHK_BASE = 8'(HDR_FIRST + HDR_FIRST + ACK_TAG + ACK_FN);

  // Result kinds.
  localparam logic [1:0] KIND_GAIN  = 2'd0;
  localparam logic [1:0] KIND_DRIVE = 2'd1;
  localparam logic [1:0] KIND_CMD   = 2'd2;
  localparam logic [1:0] KIND_ACK   = 2'd3;

  // Control command codes.
  localparam logic [2:0] CMD_READBACK   = 3'd0;
  localparam logic [2:0] CMD_ZERO_GAINS = 3'd1;
  localparam logic [2:0] CMD_ANGLE_RST  = 3'd2;
  localparam logic [2:0] CMD_MANUAL     = 3'd3;
  localparam logic [2:0] CMD_POS_ZEROED = 3'd4;
  localparam logic [2:0] CMD_AUTO       = 3'd5;

  // Result indexes within one frame's burst.
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] GAIN_WORDS     = 4'd9;
  localparam logic [IDX_W-1:0] LAST_GAIN_IDX  = 4'd15;
  localparam logic [IDX_W-1:0] LAST_DRIVE_IDX = 4'd5;
  localparam logic [IDX_W-1:0] LAST_CMD_IDX   = 4'd0;
  localparam logic [IDX_W-1:0] ACK_IDX_HDR_A  = 4'd9;
  localparam logic [IDX_W-1:0] ACK_IDX_HDR_B  = 4'd10;
  localparam logic [IDX_W-1:0] ACK_IDX_TAG    = 4'd11;
  localparam logic [IDX_W-1:0] ACK_IDX_FN     = 4'd12;
  localparam logic [IDX_W-1:0] ACK_IDX_FUNC   = 4'd13;
  localparam logic [IDX_W-1:0] ACK_IDX_SUM    = 4'd14;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             sum_init;
    logic             sum_add;
    logic             func_load;
    logic             len_load;
    logic             pay_step;
    logic             pay_write;
    logic             issue;
    logic             issue_last;
    logic [IDX_W-1:0] issue_idx;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic b_hdr_first;
    logic b_hdr_second;
    logic b_func_ok;
    logic b_len_ok;
    logic rem_zero;
    logic rem_one;
    logic sum_ok;
    logic fn_gain;
    logic fn_drive;
    logic fn_control;
    logic issue_ready;
  } ctl_stat_t;

  // Motor offset of gain result idx within its group of three motors.
  function automatic logic [2:0] gain_motor(input logic [IDX_W-1:0] idx);
    logic [2:0] m;
    case (idx)
      4'd0, 4'd1, 4'd2: m = 3'd0;
      4'd3, 4'd4, 4'd5: m = 3'd1;
      4'd6, 4'd7, 4'd8: m = 3'd2;
      default:          m = 3'd0;
    endcase
    return m;
  endfunction

  // Gain term of gain result idx: proportional, integral, derivative in turn.
  function automatic logic [1:0] gain_term(input logic [IDX_W-1:0] idx);
    logic [1:0] t;
    case (idx)
      4'd0, 4'd3, 4'd6: t = 2'd0;
      4'd1, 4'd4, 4'd7: t = 2'd1;
      4'd2, 4'd5, 4'd8: t = 2'd2;
      default:          t = 2'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- design/command_frame_receiver_core.sv -----
// Command frame receiver: one received byte per transaction in, result transactions out.
// After the checksum byte of a good frame, its first result passes the emit state,
// the build stage and the output register; then one result per cycle (16, 6 or 1)
// follows while out_stall is low. Input is stalled while the results are issued.
// Reset is synchronous: the parser returns to idle and the payload store reads as zero.
`timescale 1ns / 1ps

module command_frame_receiver_core import cfr_pkg::*; #(
  parameter int LENGTH_LIMIT   = LENGTH_LIMIT_DEF,
  parameter int STORED_PAYLOAD = STORED_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [2:0]         motor,
  output logic [1:0]         term,
  output logic signed [15:0] value,
  output logic [2:0]         command,
  output logic [7:0]         argument,
  output logic [7:0]         ack_byte,
  output logic               last
);

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;

  // Frame parser and result sequencer.
  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  // Counters, payload store and result path.
  cfr_datapath #(
    .LENGTH_LIMIT   (LENGTH_LIMIT),
    .STORED_PAYLOAD (STORED_PAYLOAD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cmd       (ctl_cmd),
    .stat      (ctl_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .motor     (motor),
    .term      (term),
    .value     (value),
    .command   (command),
    .argument  (argument),
    .ack_byte  (ack_byte),
    .last      (last)
  );

`ifndef ASSERT_OFF
  // Results are only issued while input bytes are held off.
  a_issue_stalls: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.issue |-> in_stall)
    else $error("result issued while input was open");

  // The input closes only after a byte was taken.
  a_stall_after_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled without an accepted byte");

  // Parse commands never coincide with result issue.
  a_no_parse_in_emit: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.issue |-> !(ctl_cmd.sum_add || ctl_cmd.pay_write || ctl_cmd.func_load))
    else $error("parse update during result issue");
`endif

endmodule

// ----- design/cfr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the payload store banks.
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/cfr_ctrl.sv -----
// Controller of the command frame receiver: the frame parse state machine and the
// sequencer that issues a frame's results. Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_ctrl import cfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_FUNC = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_PAY  = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] last_idx;
  logic             in_acc;

  // Input bytes are held off only while a frame's results are being issued.
  assign in_stall = (state == ST_EMIT);
  assign in_acc   = in_valid && !in_stall;

  // Index of the final result of the current function.
  always_comb begin
    if (stat.fn_gain) begin
      last_idx = LAST_GAIN_IDX;
    end else if (stat.fn_drive) begin
      last_idx = LAST_DRIVE_IDX;
    end else begin
      last_idx = LAST_CMD_IDX;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.issue_idx = idx;
    case (state)
      ST_IDLE: begin
        if (in_acc && stat.b_hdr_first) begin
          cmd.sum_init = 1'b1;
          state_next   = ST_HDR;
        end
      end
      ST_HDR: begin
        if (in_acc) begin
          if (stat.b_hdr_second) begin
            cmd.sum_add = 1'b1;
            state_next  = ST_FUNC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FUNC: begin
        if (in_acc) begin
          if (stat.b_func_ok) begin
            cmd.func_load = 1'b1;
            cmd.sum_add   = 1'b1;
            state_next    = ST_LEN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          if (stat.b_len_ok) begin
            cmd.len_load = 1'b1;
            cmd.sum_add  = 1'b1;
            state_next   = ST_PAY;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAY: begin
        if (in_acc) begin
          if (stat.rem_zero) begin
            // A zero-length frame: the byte after the length is dropped.
            state_next = ST_IDLE;
          end else begin
            cmd.pay_step  = 1'b1;
            cmd.pay_write = 1'b1;
            cmd.sum_add   = 1'b1;
            if (stat.rem_one) begin
              state_next = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        if (in_acc) begin
          // The checksum byte is stored like a payload byte.
          cmd.pay_write = 1'b1;
          if (stat.sum_ok && (stat.fn_gain || stat.fn_drive || stat.fn_control)) begin
            state_next = ST_EMIT;
            idx_next   = '0;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        cmd.issue      = 1'b1;
        cmd.issue_last = (idx == last_idx);
        if (stat.issue_ready) begin
          if (idx == last_idx) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ----- design/cfr_datapath.sv -----
// Datapath of the command frame receiver: frame counters, running sum, payload store
// banks, result build stage and output register. Depends on cfr_pkg and cfr_ram.
`timescale 1ns / 1ps

module cfr_datapath import cfr_pkg::*; #(
  parameter int LENGTH_LIMIT   = LENGTH_LIMIT_DEF,
  parameter int STORED_PAYLOAD = STORED_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  ctl_cmd_t           cmd,
  output ctl_stat_t          stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [2:0]         motor,
  output logic [1:0]         term,
  output logic signed [15:0] value,
  output logic [2:0]         command,
  output logic [7:0]         argument,
  output logic [7:0]         ack_byte,
  output logic               last
);

  // Even payload bytes live in one bank and odd ones in the other, so a word is
  // read from both banks at the same address.
  localparam int BANK_DEPTH = (STORED_PAYLOAD + 1) / 2;
  localparam int AW         = $clog2(BANK_DEPTH);

  logic [7:0]            running_sum;
  logic [7:0]            function_code;
  logic [5:0]            bytes_remaining;
  logic [5:0]            payload_count;
  logic [BANK_DEPTH-1:0] even_vld, odd_vld;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [7:0]            even_q, odd_q;
  logic                  even_ok, odd_ok;
  logic [7:0]            pay_hi, pay_lo;
  logic                  issue_go;

  // Build stage registers.
  logic       a_valid;
  logic [1:0] a_kind;
  logic [2:0] a_motor;
  logic [1:0] a_term;
  logic [7:0] a_ack;
  logic       a_last;
  logic       a_drop, a_move, a_free;
  logic       out_free, out_load;

  // Issue-time result fields.
  logic [1:0] i_kind;
  logic [2:0] i_motor;
  logic [1:0] i_term;
  logic [7:0] i_ack;
  logic [2:0] gain_base;

  // Decoded control command.
  logic       sub_known;
  logic [2:0] sub_cmd;

  // Status toward the controller.
  assign stat.b_hdr_first  = (rx_byte == HDR_FIRST);
  assign stat.b_hdr_second = (rx_byte == HDR_SECOND);
  assign stat.b_func_ok    = (rx_byte < FUNC_LIMIT);
  assign stat.b_len_ok     = (rx_byte < 8'(LENGTH_LIMIT));
  assign stat.rem_zero     = (bytes_remaining == 6'd0);
  assign stat.rem_one      = (bytes_remaining == 6'd1);
  assign stat.sum_ok       = (rx_byte == running_sum);
  assign stat.fn_gain      = (function_code == FN_GAIN_LOW) || (function_code == FN_GAIN_HIGH);
  assign stat.fn_drive     = (function_code == FN_DRIVE);
  assign stat.fn_control   = (function_code == FN_CONTROL);
  assign stat.issue_ready  = a_free;

  // Frame header registers and payload counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      function_code   <= '0;
      bytes_remaining <= '0;
      payload_count   <= '0;
    end else begin
      if (cmd.sum_init) begin
        running_sum <= rx_byte;
      end else if (cmd.sum_add) begin
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.func_load) begin
        function_code <= rx_byte;
      end
      if (cmd.len_load) begin
        bytes_remaining <= rx_byte[5:0];
        payload_count   <= '0;
      end else if (cmd.pay_step) begin
        bytes_remaining <= bytes_remaining - 6'd1;
        payload_count   <= payload_count + 6'd1;
      end
    end
  end

  // Store writes: only bytes that fall inside the store are kept.
  assign wr_en   = cmd.pay_write && ({1'b0, payload_count} < 7'(STORED_PAYLOAD));
  assign wr_addr = AW'(payload_count >> 1);

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      even_vld <= '0;
      odd_vld  <= '0;
    end else if (wr_en) begin
      if (payload_count[0]) begin
        odd_vld[wr_addr] <= 1'b1;
      end else begin
        even_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // Word index of the result being issued; commands read word zero.
  assign rd_addr  = (cmd.issue_idx < GAIN_WORDS) ? AW'(cmd.issue_idx) : '0;
  assign issue_go = cmd.issue && a_free;

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (wr_en && !payload_count[0]),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .re    (issue_go),
    .raddr (rd_addr),
    .rdata (even_q)
  );

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (wr_en && payload_count[0]),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .re    (issue_go),
    .raddr (rd_addr),
    .rdata (odd_q)
  );

  // Valid flags travel with the read data.
  always_ff @(posedge clk) begin
    if (issue_go) begin
      even_ok <= even_vld[rd_addr];
      odd_ok  <= odd_vld[rd_addr];
    end
  end

  assign pay_hi = even_ok ? even_q : 8'd0;
  assign pay_lo = odd_ok ? odd_q : 8'd0;

  // Result fields that depend on the function, the result index and, for acknowledges, the running sum.
  assign gain_base = (function_code == FN_GAIN_HIGH) ? 3'd3 : 3'd0;

  always_comb begin
    i_kind  = KIND_CMD;
    i_motor = '0;
    i_term  = '0;
    i_ack   = '0;
    if (stat.fn_gain) begin
      if (cmd.issue_idx < GAIN_WORDS) begin
        i_kind  = KIND_GAIN;
        i_motor = gain_base + gain_motor(cmd.issue_idx);
        i_term  = gain_term(cmd.issue_idx);
      end else begin
        i_kind = KIND_ACK;
        case (cmd.issue_idx)
          ACK_IDX_HDR_A: i_ack = HDR_FIRST;
          ACK_IDX_HDR_B: i_ack = HDR_FIRST;
          ACK_IDX_TAG:   i_ack = ACK_TAG;
          ACK_IDX_FN:    i_ack = ACK_FN;
          ACK_IDX_FUNC:  i_ack = function_code;
          ACK_IDX_SUM:   i_ack = running_sum;
          default:       i_ack = ACK_CHK_BASE + function_code + running_sum;
        endcase
      end
    end else if (stat.fn_drive) begin
      i_kind  = KIND_DRIVE;
      i_motor = cmd.issue_idx[2:0];
    end
  end

  // Decode the control subcommand from the first payload byte.
  always_comb begin
    sub_known = 1'b1;
    case (pay_hi)
      SUB_READBACK:   sub_cmd = CMD_READBACK;
      SUB_ZERO_GAINS: sub_cmd = CMD_ZERO_GAINS;
      SUB_ANGLE_RST:  sub_cmd = CMD_ANGLE_RST;
      SUB_MANUAL:     sub_cmd = CMD_MANUAL;
      SUB_POS_ZEROED: sub_cmd = CMD_POS_ZEROED;
      SUB_AUTO:       sub_cmd = CMD_AUTO;
      default: begin
        sub_cmd   = CMD_READBACK;
        sub_known = 1'b0;
      end
    endcase
  end

  // Build stage handshake; an unknown subcommand is discarded here.
  assign out_free = !out_valid || !out_stall;
  assign a_drop   = (a_kind == KIND_CMD) && !sub_known;
  assign a_move   = a_valid && (a_drop || out_free);
  assign a_free   = !a_valid || a_move;
  assign out_load = a_valid && !a_drop && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (issue_go) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go) begin
      a_kind  <= i_kind;
      a_motor <= i_motor;
      a_term  <= i_term;
      a_ack   <= i_ack;
      a_last  <= cmd.issue_last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind     <= a_kind;
      motor    <= a_motor;
      term     <= a_term;
      ack_byte <= a_ack;
      last     <= a_last;
      if ((a_kind == KIND_GAIN) || (a_kind == KIND_DRIVE)) begin
        value <= $signed({pay_hi, pay_lo});
      end else begin
        value <= '0;
      end
      if (a_kind == KIND_CMD) begin
        command  <= sub_cmd;
        argument <= (sub_cmd == CMD_MANUAL) ? pay_lo : 8'd0;
      end else begin
        command  <= '0;
        argument <= '0;
      end
    end
  end

endmodule
